[sv/dsd_pkg.sv]
// Shared types and constants for the decimal scaled divider.
// Holds the transfer structs, status codes and sequencer states.
// No dependencies.
package dsd_pkg;

  localparam logic [31:0] MagMax      = 32'h7FFF_FFFF;
  // 0x7FFFFFFF / 10: smallest divisor magnitude that is refused
  localparam logic [31:0] BigDivisor  = 32'd214748364;
  localparam logic [3:0]  MaxPlaces   = 4'd9;
  localparam logic [4:0]  IntSteps    = 5'd31;
  localparam logic [1:0]  DigitSteps  = 2'd3;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_DIV_ZERO    = 2'd1,
    STAT_BIG_DIVISOR = 2'd2,
    STAT_OVERFLOW    = 2'd3
  } dsd_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INTDIV,
    ST_SCALE,
    ST_DIGIT,
    ST_ROUND,
    ST_FINISH
  } dsd_state_e;

  typedef struct packed {
    logic signed [31:0] dividend;
    logic signed [31:0] divisor;
    logic [3:0]         decimal_places;
  } dsd_in_t;

  typedef struct packed {
    logic signed [31:0] quotient;
    dsd_status_e        status;
  } dsd_out_t;

endpackage

[sv/decimal_scaled_divider.sv]
// Rounded decimal fixed-point divider: top level and sequencer.
// Depends on dsd_pkg for transfer structs, status codes and states.
// One shared 32-bit compare-subtract unit does all the division work.
//
// Places are clamped to 9; a zero or oversized divisor goes from the
// divisor check straight to the output. The work is done by the single
// compare-subtract unit: a check of the divisor, 32 integer quotient bits
// at one bit per cycle, then for each decimal place a multiply by ten and
// four restoring steps for the digit, then a rounding step and a step to
// sign the result, which waits while the output register is stalled.
// The block takes no new item until the current one has reached the output
// register, which holds a finished result while the next item is at work.
module decimal_scaled_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dsd_pkg::dsd_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dsd_pkg::dsd_out_t out_o
);

  dsd_pkg::dsd_state_e  state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  dsd_pkg::dsd_out_t    out_q, out_d;

  logic [31:0]          q_q, q_d;        // dividend, then quotient magnitude
  logic [30:0]          rem_q, rem_d;
  logic [31:0]          b_q, b_d;        // divisor magnitude
  logic [3:0]           places_q, places_d;
  logic [4:0]           cnt_q, cnt_d;
  logic [3:0]           dig_q, dig_d;
  logic                 neg_q, neg_d;
  logic                 ovf_q, ovf_d;
  dsd_pkg::dsd_status_e stat_q, stat_d;

  // shared compare-subtract unit
  logic [31:0] cand;
  logic [31:0] sub;
  logic [32:0] diff;
  logic        ge;

  logic [31:0] dvd_mag, dvs_mag;
  logic [31:0] nq;
  logic [34:0] q10;
  logic [30:0] rem10;
  logic [3:0]  digit;
  logic [31:0] dsum, rsum, mag, res;

  always_comb begin
    unique case (state_q)
      dsd_pkg::ST_INTDIV: begin
        cand = {rem_q, q_q[31]};
        sub  = b_q;
      end
      dsd_pkg::ST_DIGIT: begin
        cand = {1'b0, rem_q};
        sub  = b_q << cnt_q[1:0];
      end
      default: begin
        cand = {rem_q, 1'b0};
        sub  = b_q;
      end
    endcase
    diff = {1'b0, cand} - {1'b0, sub};
    ge   = ~diff[32];
  end

  assign dvd_mag = in_i.dividend[31] ? (32'd0 - in_i.dividend) : in_i.dividend;
  assign dvs_mag = in_i.divisor[31]  ? (32'd0 - in_i.divisor)  : in_i.divisor;

  assign nq    = {q_q[30:0], ge};
  assign q10   = {q_q, 3'b000} + {2'b00, q_q, 1'b0};
  assign rem10 = {rem_q[27:0], 3'b000} + {rem_q[29:0], 1'b0};
  assign digit = {dig_q[2:0], ge};
  assign dsum  = q_q + {28'd0, digit};
  assign rsum  = q_q + {31'd0, ge};
  assign mag   = ovf_q ? dsd_pkg::MagMax : q_q;
  assign res   = neg_q ? (32'd0 - mag) : mag;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    q_d         = q_q;
    rem_d       = rem_q;
    b_d         = b_q;
    places_d    = places_q;
    cnt_d       = cnt_q;
    dig_d       = dig_q;
    neg_d       = neg_q;
    ovf_d       = ovf_q;
    stat_d      = stat_q;
    in_stall_o  = (state_q != dsd_pkg::ST_IDLE);

    unique case (state_q)
      dsd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          q_d      = dvd_mag;
          b_d      = dvs_mag;
          neg_d    = in_i.dividend[31] ^ in_i.divisor[31];
          places_d = (in_i.decimal_places > dsd_pkg::MaxPlaces) ?
                     dsd_pkg::MaxPlaces : in_i.decimal_places;
          state_d  = dsd_pkg::ST_CHECK;
        end
      end
      dsd_pkg::ST_CHECK: begin
        rem_d = '0;
        ovf_d = 1'b0;
        cnt_d = dsd_pkg::IntSteps;
        priority if (b_q == 32'd0) begin
          stat_d  = dsd_pkg::STAT_DIV_ZERO;
          state_d = dsd_pkg::ST_FINISH;
        end else if (b_q >= dsd_pkg::BigDivisor) begin
          stat_d  = dsd_pkg::STAT_BIG_DIVISOR;
          state_d = dsd_pkg::ST_FINISH;
        end else begin
          stat_d  = dsd_pkg::STAT_OK;
          state_d = dsd_pkg::ST_INTDIV;
        end
      end
      dsd_pkg::ST_INTDIV: begin
        rem_d = ge ? diff[30:0] : cand[30:0];
        q_d   = nq;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          // only the most negative dividend over one lands here
          if (nq[31]) ovf_d = 1'b1;
          state_d = (places_q == 4'd0) ? dsd_pkg::ST_ROUND : dsd_pkg::ST_SCALE;
        end
      end
      dsd_pkg::ST_SCALE: begin
        rem_d = rem10;
        dig_d = '0;
        cnt_d = {3'b000, dsd_pkg::DigitSteps};
        if (q10 > {3'b000, dsd_pkg::MagMax}) ovf_d = 1'b1;
        else q_d = q10[31:0];
        state_d = dsd_pkg::ST_DIGIT;
      end
      dsd_pkg::ST_DIGIT: begin
        rem_d = ge ? diff[30:0] : cand[30:0];
        dig_d = digit;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q[1:0] == 2'd0) begin
          q_d      = dsum;
          if (dsum[31]) ovf_d = 1'b1;
          places_d = places_q - 4'd1;
          state_d  = (places_q == 4'd1) ? dsd_pkg::ST_ROUND : dsd_pkg::ST_SCALE;
        end
      end
      dsd_pkg::ST_ROUND: begin
        // half up: twice the remainder against the divisor
        q_d = rsum;
        if (rsum[31]) ovf_d = 1'b1;
        state_d = dsd_pkg::ST_FINISH;
      end
      dsd_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (stat_q != dsd_pkg::STAT_OK) begin
            out_d.quotient = '0;
            out_d.status   = stat_q;
          end else begin
            out_d.quotient = $signed(res);
            out_d.status   = ovf_q ? dsd_pkg::STAT_OVERFLOW : dsd_pkg::STAT_OK;
          end
          state_d = dsd_pkg::ST_IDLE;
        end
      end
      default: state_d = dsd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    q_q      <= q_d;
    rem_q    <= rem_d;
    b_q      <= b_d;
    places_q <= places_d;
    cnt_q    <= cnt_d;
    dig_q    <= dig_d;
    neg_q    <= neg_d;
    ovf_q    <= ovf_d;
    stat_q   <= stat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // remainder stays below the divisor through the integer part and at each scale step
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dsd_pkg::ST_INTDIV || state_q == dsd_pkg::ST_SCALE)
    |-> ({1'b0, rem_q} < b_q))
    else $error("remainder not below divisor");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dsd_pkg::ST_DIGIT && cnt_q[1:0] == 2'd0) |-> (digit <= 4'd9))
    else $error("decimal digit out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_o.status == dsd_pkg::STAT_DIV_ZERO ||
                     out_o.status == dsd_pkg::STAT_BIG_DIVISOR))
    |-> (out_o.quotient == 32'sd0))
    else $error("error result carries nonzero quotient");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status == dsd_pkg::STAT_OVERFLOW)
    |-> (out_o.quotient == 32'sh7FFF_FFFF || out_o.quotient == -32'sh7FFF_FFFF))
    else $error("overflow result not saturated");

endmodule
